/* sv/ifla_pkg.sv */
// shared types and constants of the index free list allocator
`timescale 1ns / 1ps
`default_nettype none

package ifla_pkg;

	// slot table geometry
	localparam int SLOTS   = 256;
	localparam int IDX_W   = $clog2(SLOTS);
	localparam int LINK_W  = IDX_W + 1;
	localparam int COUNT_W = LINK_W;

	// null link: end of chain or empty list
	localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(SLOTS);

	// configuration register map
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic REG_SLOT_COUNT = 1'b0;
	localparam logic [COUNT_W-1:0] SLOT_COUNT_RST = COUNT_W'(256);

	// request kinds
	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_REBUILD = 2'd2
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// controller to datapath commands
	typedef struct packed {
		logic emit_empty;
		logic emit_nop;
		logic start_alloc;
		logic finish_alloc;
		logic do_free;
		logic clear_head;
		logic start_build;
		logic build_step;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_free;
		logic head_nil;
		logic count_zero;
		logic build_last;
	} stat_t;

endpackage

`default_nettype wire

/* sv/ifla_dp.sv */
// datapath: head register, link table, rebuild counter and result register
`timescale 1ns / 1ps
`default_nettype none

module ifla_dp
	import ifla_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cmd_t                 cmd,
	input  wire logic [COUNT_W-1:0]   slot_count,
	input  wire logic [IDX_W-1:0]     in_index,
	output stat_t                     stat,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [IDX_W-1:0]          out_index,
	output status_t                   out_status
);

	logic [LINK_W-1:0]  head_q;
	logic [IDX_W-1:0]   ctr_q;
	logic [LINK_W-1:0]  next_mem [SLOTS];
	logic [LINK_W-1:0]  rdata_q;
	logic               out_valid_q;
	logic [IDX_W-1:0]   out_index_q;
	status_t            out_status_q;

	logic [COUNT_W-1:0] eff_count;
	logic               range_err;
	logic               build_last;
	logic [LINK_W-1:0]  popped_link;
	logic               we;
	logic [IDX_W-1:0]   waddr;
	logic [LINK_W-1:0]  wdata;
	logic               out_load;
	logic [IDX_W-1:0]   load_index;
	status_t            load_status;

	// slot count saturates at the table size
	assign eff_count = (slot_count > COUNT_W'(SLOTS)) ? COUNT_W'(SLOTS) : slot_count;
	assign range_err = ({1'b0, in_index} >= eff_count);
	assign build_last = ((COUNT_W'(ctr_q) + COUNT_W'(1)) == eff_count);
	assign popped_link = (rdata_q >= NIL_LINK) ? NIL_LINK : rdata_q;

	// status toward the controller
	always_comb begin
		stat.out_free   = !out_valid_q || out_ready;
		stat.head_nil   = (head_q >= NIL_LINK);
		stat.count_zero = (eff_count == '0);
		stat.build_last = build_last;
	end

	// table write port select
	always_comb begin
		we    = 1'b0;
		waddr = ctr_q;
		wdata = NIL_LINK;
		priority if (cmd.do_free) begin
			we    = !range_err;
			waddr = in_index;
			wdata = head_q;
		end else if (cmd.finish_alloc) begin
			we    = 1'b1;
			waddr = head_q[IDX_W-1:0];
			wdata = NIL_LINK;
		end else if (cmd.build_step) begin
			we    = 1'b1;
			waddr = ctr_q;
			wdata = build_last ? NIL_LINK : (LINK_W'(ctr_q) + LINK_W'(1));
		end
	end

	// link table, registered read of the head entry
	always_ff @(posedge clk) begin
		if (we) begin
			next_mem[waddr] <= wdata;
		end
		if (cmd.start_alloc) begin
			rdata_q <= next_mem[head_q[IDX_W-1:0]];
		end
	end

	// head register and rebuild counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= NIL_LINK;
			ctr_q  <= '0;
		end else begin
			if (cmd.do_free && !range_err) begin
				head_q <= {1'b0, in_index};
			end else if (cmd.finish_alloc) begin
				head_q <= popped_link;
			end else if (cmd.clear_head) begin
				head_q <= NIL_LINK;
			end else if (cmd.build_step && build_last) begin
				head_q <= '0;
			end
			if (cmd.start_build) begin
				ctr_q <= '0;
			end else if (cmd.build_step) begin
				ctr_q <= ctr_q + IDX_W'(1);
			end
		end
	end

	// result beat contents
	assign out_load = cmd.emit_empty || cmd.emit_nop || cmd.finish_alloc || cmd.do_free
		|| cmd.clear_head || (cmd.build_step && build_last);

	always_comb begin
		load_index  = '0;
		load_status = ST_DONE;
		if (cmd.finish_alloc) begin
			load_index = head_q[IDX_W-1:0];
		end
		if (cmd.emit_empty) begin
			load_status = ST_EMPTY;
		end else if (cmd.do_free && range_err) begin
			load_status = ST_RANGE;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_index_q  <= load_index;
			out_status_q <= load_status;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_index  = out_index_q;
	assign out_status = out_status_q;

	// a result never overwrites a beat that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || out_ready))
		else $error("result loaded over a pending beat");

	// a finished allocate always shows a successful beat
	a_alloc_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish_alloc |=> (out_valid_q && out_status_q == ST_DONE))
		else $error("allocate finished without a done beat");

	// an accepted free makes the freed slot the new head
	a_free_head: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.do_free && !range_err) |=> (head_q == {1'b0, $past(in_index)}))
		else $error("freed slot did not become the head");

endmodule

`default_nettype wire

/* sv/ifla_ctrl.sv */
// controller state machine that sequences allocate, free and rebuild requests
`timescale 1ns / 1ps
`default_nettype none

module ifla_ctrl
	import ifla_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic [1:0]  in_opcode,
	output logic             in_ready,
	output cmd_t             cmd,
	input  wire stat_t       stat
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_ALLOC = 3'b010,
		S_BUILD = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;
	op_t    op;

	assign in_ready = (state_q == S_IDLE) && stat.out_free;
	assign accept   = in_valid && in_ready;
	assign op       = op_t'(in_opcode);

	// next state and command decode
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (op)
						OP_ALLOC: begin
							if (stat.head_nil) begin
								cmd.emit_empty = 1'b1;
							end else begin
								cmd.start_alloc = 1'b1;
								state_d = S_ALLOC;
							end
						end
						OP_FREE: begin
							cmd.do_free = 1'b1;
						end
						OP_REBUILD: begin
							if (stat.count_zero) begin
								cmd.clear_head = 1'b1;
							end else begin
								cmd.start_build = 1'b1;
								state_d = S_BUILD;
							end
						end
						default: begin
							cmd.emit_nop = 1'b1;
						end
					endcase
				end
			end
			S_ALLOC: begin
				cmd.finish_alloc = 1'b1;
				state_d = S_IDLE;
			end
			S_BUILD: begin
				cmd.build_step = 1'b1;
				if (stat.build_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// an allocate leaves the table read state for idle in the following cycle
	a_alloc_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALLOC) |=> (state_q == S_IDLE))
		else $error("allocate did not finish after the table read");

	// an allocate on a non-empty list goes through the read state
	a_alloc_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == OP_ALLOC && !stat.head_nil) |=> (state_q == S_ALLOC))
		else $error("allocate on a non-empty list skipped the table read");

endmodule

`default_nettype wire

/* sv/index_free_list_allocator_top.sv */
// Index free list allocator: hands out and takes back slot indices 0..255.
// Request stream (s_axis): tuser carries the opcode (0 allocate, 1 free,
// 2 rebuild), tdata the slot index of a free. Result stream (m_axis): tdata
// is the granted index (zero unless an allocate succeeds), tuser the status
// (0 done, 1 list empty, 2 freed index out of range). Every request yields
// exactly one result beat.
// Register slot_count (APB, byte address 0) sets how many slots a rebuild
// chains; values above 256 act as 256. Write it only while the block is idle.
// Sequencing: free, an allocate on an empty list and unknown opcodes finish
// at acceptance; an allocate passes through a read state, set by the
// registered read of the link table; a rebuild steps through the slots,
// one table write per slot. The result is registered, in the cycle
// after the last work cycle, and the next request is taken in the same cycle
// the pending beat is taken. One request is in work at a time.
// After reset the list is empty (allocate reports empty) until the first
// rebuild or accepted free; the link table holds no reset value and needs no clearing pass.
// While the receiver stalls, the result beat holds and no new request is taken.
`timescale 1ns / 1ps
`default_nettype none

module index_free_list_allocator_top
	import ifla_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// request channel
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [7:0]            s_axis_tdata,  // [7:0] slot_index
	input  wire logic [1:0]            s_axis_tuser,  // [1:0] opcode
	// result channel
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [7:0]                 m_axis_tdata,  // [7:0] granted_index
	output logic [1:0]                 m_axis_tuser,  // [1:0] status
	// configuration port
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0]      prdata,
	output logic                       pready
);

	cmd_t               cmd;
	stat_t              stat;
	logic [COUNT_W-1:0] slot_count_q;
	logic               cfg_write;
	logic               reg_sel;
	status_t            out_status;

	// register access
	assign pready    = 1'b1;
	assign reg_sel   = paddr[2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= SLOT_COUNT_RST;
		end else if (cfg_write && reg_sel == REG_SLOT_COUNT) begin
			slot_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	assign prdata = (reg_sel == REG_SLOT_COUNT) ? CFG_DATA_W'(slot_count_q) : '0;

	// sequencer
	ifla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_opcode (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// table, head and result register
	ifla_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.slot_count (slot_count_q),
		.in_index   (s_axis_tdata[IDX_W-1:0]),
		.stat       (stat),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_index  (m_axis_tdata[IDX_W-1:0]),
		.out_status (out_status)
	);

	assign m_axis_tuser = out_status;

endmodule

`default_nettype wire

/* tb/sv/tb_index_free_list_allocator_top.sv */
// testbench for the index free list allocator: directed table plus random requests, scoreboarded
`timescale 1ns / 1ps

module tb_index_free_list_allocator_top;
	import ifla_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int N_DIR = 28;
	localparam int N_PHASE = 6;
	localparam int PHASE_ITEMS = 170;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [CFG_ADDR_W-1:0] SLOT_COUNT_ADDR = CFG_ADDR_W'(4 * REG_SLOT_COUNT);

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	// one row of the directed table; cfg rows carry the slot count in arg
	typedef struct packed {
		row_kind_t  kind;
		logic [1:0] opc;
		logic [8:0] arg;
		logic       typed;
		logic [7:0] granted;
		status_t    status;
	} dir_row_t;

	// one expected result beat
	typedef struct packed {
		logic [1:0] opc;
		logic [7:0] granted;
		status_t    status;
	} grant_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;  // [7:0] slot_index
	logic [1:0] s_axis_tuser = '0;  // [1:0] opcode
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;       // [7:0] granted_index
	logic [1:0] m_axis_tuser;       // [1:0] status
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;

	// typed-in expectation travelling with the current request beat
	logic req_typed = 1'b0;
	logic [7:0] req_exp_granted = '0;
	status_t req_exp_status = ST_DONE;
	logic calm = 1'b0;

	// allocator mirror
	logic [LINK_W-1:0] free_head;
	logic [LINK_W-1:0] next_link [SLOTS];
	logic [COUNT_W-1:0] slot_count_reg;

	grant_result_t expected_grants[$];
	logic [7:0] held_slots[$];

	int err_cnt = 0;
	int cycle_cnt = 0;
	int rx_hold = 0;
	int n_req = 0;
	int n_res = 0;
	int n_grant = 0;
	int n_empty = 0;
	int n_range = 0;
	int n_rebuild = 0;
	int n_cfg = 0;

	dir_row_t dir_table [N_DIR] = '{
		'{ROW_REQ, OP_ALLOC,   9'd0,   1'b1, 8'd0,   ST_EMPTY},
		'{ROW_REQ, OP_UNUSED,  9'd255, 1'b1, 8'd0,   ST_DONE},
		'{ROW_REQ, OP_FREE,    9'd255, 1'b1, 8'd0,   ST_DONE},
		'{ROW_REQ, OP_ALLOC,   9'd0,   1'b1, 8'd255, ST_DONE},
		'{ROW_REQ, OP_ALLOC,   9'd0,   1'b1, 8'd0,   ST_EMPTY},
		'{ROW_REQ, OP_REBUILD, 9'd0,   1'b1, 8'd0,   ST_DONE},
		'{ROW_REQ, OP_ALLOC,   9'd0,   1'b1, 8'd0,   ST_DONE},
		'{ROW_REQ, OP_ALLOC,   9'd170, 1'b1, 8'd1,   ST_DONE},
		'{ROW_REQ, OP_FREE,    9'd0,   1'b1, 8'd0,   ST_DONE},
		'{ROW_REQ, OP_ALLOC,   9'd85,  1'b1, 8'd0,   ST_DONE},
		'{ROW_REQ, OP_ALLOC,   9'd0,   1'b0, 8'd0,   ST_DONE},
		'{ROW_CFG, OP_ALLOC,   9'd1,   1'b0, 8'd0,   ST_DONE},
		'{ROW_REQ, OP_REBUILD, 9'd0,   1'b1, 8'd0,   ST_DONE},
		'{ROW_REQ, OP_ALLOC,   9'd0,   1'b1, 8'd0,   ST_DONE},
		'{ROW_REQ, OP_ALLOC,   9'd0,   1'b1, 8'd0,   ST_EMPTY},
		'{ROW_REQ, OP_FREE,    9'd1,   1'b1, 8'd0,   ST_RANGE},
		'{ROW_REQ, OP_FREE,    9'd255, 1'b1, 8'd0,   ST_RANGE},
		'{ROW_REQ, OP_FREE,    9'd0,   1'b1, 8'd0,   ST_DONE},
		'{ROW_CFG, OP_ALLOC,   9'd0,   1'b0, 8'd0,   ST_DONE},
		'{ROW_REQ, OP_REBUILD, 9'd0,   1'b1, 8'd0,   ST_DONE},
		'{ROW_REQ, OP_ALLOC,   9'd0,   1'b1, 8'd0,   ST_EMPTY},
		'{ROW_REQ, OP_FREE,    9'd0,   1'b1, 8'd0,   ST_RANGE},
		'{ROW_CFG, OP_ALLOC,   9'd511, 1'b0, 8'd0,   ST_DONE},
		'{ROW_REQ, OP_REBUILD, 9'd0,   1'b1, 8'd0,   ST_DONE},
		'{ROW_REQ, OP_FREE,    9'd255, 1'b1, 8'd0,   ST_DONE},
		'{ROW_REQ, OP_ALLOC,   9'd0,   1'b1, 8'd255, ST_DONE},
		'{ROW_REQ, OP_ALLOC,   9'd0,   1'b0, 8'd0,   ST_DONE},
		'{ROW_REQ, OP_UNUSED,  9'd0,   1'b1, 8'd0,   ST_DONE}
	};

	logic [8:0] phase_count [N_PHASE] = '{9'd256, 9'd37, 9'd1, 9'd256, 9'd0, 9'd300};
	int phase_alloc_pct [N_PHASE] = '{45, 60, 50, 75, 40, 55};

	index_free_list_allocator_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #6 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("tb_index_free_list_allocator_top NOT OK");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// advance the allocator mirror by one request and return its result
	function automatic grant_result_t predict_grant(input logic [1:0] opc, input logic [7:0] idx);
		grant_result_t res;
		int cnt;
		logic [LINK_W-1:0] taken;
		res.opc = opc;
		res.granted = '0;
		res.status = ST_DONE;
		cnt = (int'(slot_count_reg) > SLOTS) ? SLOTS : int'(slot_count_reg);
		case (opc)
			OP_ALLOC: begin
				if (free_head >= LINK_W'(SLOTS)) begin
					res.status = ST_EMPTY;
				end else begin
					taken = free_head;
					free_head = next_link[taken[IDX_W-1:0]];
					if (free_head > LINK_W'(SLOTS))
						free_head = NIL_LINK;
					next_link[taken[IDX_W-1:0]] = NIL_LINK;
					res.granted = taken[7:0];
				end
			end
			OP_FREE: begin
				if (int'(idx) >= cnt) begin
					res.status = ST_RANGE;
				end else begin
					next_link[idx] = free_head;
					free_head = LINK_W'(idx);
				end
			end
			OP_REBUILD: begin
				if (cnt == 0) begin
					free_head = NIL_LINK;
				end else begin
					for (int i = 0; i + 1 < cnt; i++)
						next_link[i] = LINK_W'(i + 1);
					next_link[cnt - 1] = NIL_LINK;
					free_head = '0;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// result checking, request capture and result-side stalls
	always @(posedge clk) begin
		grant_result_t exp_res;
		grant_result_t pred;
		// result beat against the oldest expectation
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_res++;
			if (expected_grants.size() == 0) begin
				$error("result beat with nothing pending: granted_index %0d status %0d",
					m_axis_tdata, m_axis_tuser);
				err_cnt++;
			end else begin
				exp_res = expected_grants.pop_front();
				if (m_axis_tdata !== exp_res.granted) begin
					$error("granted_index mismatch: expected %0d, actual %0d",
						exp_res.granted, m_axis_tdata);
					err_cnt++;
				end
				if (m_axis_tuser !== exp_res.status) begin
					$error("status mismatch: expected %0d, actual %0d",
						exp_res.status, m_axis_tuser);
					err_cnt++;
				end
				if (exp_res.status == ST_EMPTY)
					n_empty++;
				if (exp_res.status == ST_RANGE)
					n_range++;
				if (exp_res.opc == OP_ALLOC && exp_res.status == ST_DONE) begin
					n_grant++;
					held_slots.push_back(exp_res.granted);
				end
			end
		end
		// request beat updates the mirror
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			pred = predict_grant(s_axis_tuser, s_axis_tdata);
			if (s_axis_tuser == OP_REBUILD)
				n_rebuild++;
			if (req_typed) begin
				pred.granted = req_exp_granted;
				pred.status = req_exp_status;
			end
			expected_grants.push_back(pred);
		end
		// result-side backpressure
		if (rx_hold > 0) begin
			rx_hold--;
			m_axis_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 99) < 25) begin
			rx_hold = pick_gap();
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// present one request beat and hold it until taken
	task automatic send_beat(input logic [1:0] opc, input logic [7:0] idx, input logic typed,
		input logic [7:0] granted, input status_t status);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= opc;
		s_axis_tdata <= idx;
		req_typed <= typed;
		req_exp_granted <= granted;
		req_exp_status <= status;
		do @(posedge clk); while (!s_axis_tready);
		n_req++;
	endtask

	task automatic idle_gap(input int n);
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// stop sending and wait for every pending result
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_grants.size() != 0)
			@(posedge clk);
	endtask

	// one apb transfer to the slot_count register
	task automatic apb_access(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= SLOT_COUNT_ADDR;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// idle the block, write slot_count, read it back
	task automatic set_slot_count(input logic [8:0] value);
		logic [31:0] rd;
		wait_drained();
		apb_access(1'b1, {23'd0, value}, rd);
		slot_count_reg = value;
		apb_access(1'b0, '0, rd);
		if (rd !== {23'd0, value}) begin
			$error("slot_count readback mismatch: expected %0d, actual %0d", value, rd);
			err_cnt++;
		end
		n_cfg++;
	endtask

	// stimulus
	initial begin
		int ph;
		int k;
		int r;
		int pos;
		logic [8:0] cnt_val;
		logic [7:0] idx;
		logic [1:0] opc;
		logic [31:0] rd;
		bit calm_now;

		free_head = NIL_LINK;
		slot_count_reg = SLOT_COUNT_RST;
		for (int i = 0; i < SLOTS; i++)
			next_link[i] = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// register value after reset
		apb_access(1'b0, '0, rd);
		if (rd !== {23'd0, SLOT_COUNT_RST}) begin
			$error("slot_count reset value mismatch: expected %0d, actual %0d",
				SLOT_COUNT_RST, rd);
			err_cnt++;
		end

		// directed table
		for (int d = 0; d < N_DIR; d++) begin
			if (dir_table[d].kind == ROW_CFG) begin
				set_slot_count(dir_table[d].arg);
			end else begin
				idle_gap(pick_gap());
				send_beat(dir_table[d].opc, dir_table[d].arg[7:0], dir_table[d].typed,
					dir_table[d].granted, dir_table[d].status);
			end
		end

		// random phases, each under its own slot count
		for (ph = 0; ph < N_PHASE; ph++) begin
			cnt_val = (ph == 4) ? 9'($urandom_range(2, 255)) : phase_count[ph];
			set_slot_count(cnt_val);
			held_slots.delete();
			send_beat(OP_REBUILD, 8'($urandom_range(0, 255)), 1'b0, '0, ST_DONE);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				calm_now = (k >= 60 && k < 90);
				calm <= calm_now;
				// let everything drain once mid-phase
				if (k == 120)
					wait_drained();
				if (!calm_now)
					idle_gap(pick_gap());
				idx = 8'($urandom_range(0, 255));
				r = $urandom_range(0, 99);
				if (r < phase_alloc_pct[ph]) begin
					opc = OP_ALLOC;
				end else begin
					r = $urandom_range(0, 99);
					if (r < 80) begin
						// return a slot that was handed out
						opc = OP_FREE;
						if (held_slots.size() != 0) begin
							pos = $urandom_range(0, held_slots.size() - 1);
							idx = held_slots[pos];
							held_slots.delete(pos);
						end
					end else if (r < 92) begin
						opc = OP_FREE;
					end else if (r < 96) begin
						opc = OP_REBUILD;
						held_slots.delete();
					end else begin
						opc = OP_UNUSED;
					end
				end
				send_beat(opc, idx, 1'b0, '0, ST_DONE);
			end
			calm <= 1'b0;
		end

		// drain and let the block settle
		wait_drained();
		repeat (20) @(posedge clk);

		$display("run covered %0d requests and %0d results under %0d slot_count writes",
			n_req, n_res, n_cfg);
		$display("seen %0d grants, %0d empty-list replies, %0d out-of-range frees, %0d rebuilds",
			n_grant, n_empty, n_range, n_rebuild);
		if (err_cnt == 0 && expected_grants.size() == 0) begin
			$display("tb_index_free_list_allocator_top OK");
		end else begin
			$display("tb_index_free_list_allocator_top NOT OK");
		end
		$finish;
	end

endmodule
